// ===== design/dpt_pkg.sv =====
package dpt_pkg;

   localparam int COORD_BITS     = 12;
   localparam int HIT_BITS       = 3;
   localparam int FRAME_BITS     = 8;
   localparam int RADIUS_BITS    = 12;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 12;
   localparam int SQ_BITS        = 2 * COORD_BITS;
   localparam int D2_BITS        = SQ_BITS + 1;
   localparam int R2_BITS        = 2 * RADIUS_BITS;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MATCH_RADIUS     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAMES_PER_DECAY = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIT_CAP          = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_HITS         = 2'd3;

   localparam logic [RADIUS_BITS-1:0] MATCH_RADIUS_RESET     = 12'd100;
   localparam logic [FRAME_BITS-1:0]  FRAMES_PER_DECAY_RESET = 8'd6;
   localparam logic [HIT_BITS-1:0]    HIT_CAP_RESET          = 3'd6;
   localparam logic [HIT_BITS-1:0]    MIN_HITS_RESET         = 3'd1;

   localparam logic [HIT_BITS-1:0] FIRST_HITS = 3'd1;

   localparam logic ACTION_DETECT    = 1'b0;
   localparam logic ACTION_FRAME_END = 1'b1;

   typedef struct packed {
      logic                  action;
      logic [COORD_BITS-1:0] point_x;
      logic [COORD_BITS-1:0] point_y;
   } req_word_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] best_x;
      logic [COORD_BITS-1:0] best_y;
      logic                  dropped;
   } rsp_word_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [HIT_BITS-1:0]   hits;
   } entry_type;

   typedef struct packed {
      logic load;
      logic run;
      logic commit_det;
      logic commit_frame;
   } ctrl_cmd_type;

   typedef struct packed {
      logic frame_end;
      logic decay_due;
      logic scan_done;
   } dp_status_type;

endpackage

// ===== design/dpt_ram.sv =====
module dpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/dpt_ctrl.sv =====
module dpt_ctrl import dpt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy,
   output logic          rsp_valid
);

   typedef enum logic [1:0] {
      IDLE,
      DISPATCH,
      SCAN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = DISPATCH;
            end
         end
         DISPATCH: begin
            // frame end without decay needs no pass over the table
            if (status.frame_end && !status.decay_due) begin
               cmd.commit_frame = 1'b1;
               rsp_valid_in     = 1'b1;
               state_in         = IDLE;
            end else begin
               state_in = SCAN;
            end
         end
         SCAN: begin
            cmd.run = 1'b1;
            if (status.scan_done) begin
               cmd.commit_frame = status.frame_end;
               cmd.commit_det   = !status.frame_end;
               rsp_valid_in     = 1'b1;
               state_in         = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/dpt_datapath.sv =====
module dpt_datapath import dpt_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  req_word_type              req_word,
   input  ctrl_cmd_type              cmd,
   output dp_status_type             status,
   output rsp_word_type              rsp_word
);

   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int IDX_W = $clog2(ENTRIES);

   // configuration
   logic [RADIUS_BITS-1:0] radius_ff;
   logic [FRAME_BITS-1:0]  fpd_ff;
   logic [HIT_BITS-1:0]    cap_ff;
   logic [HIT_BITS-1:0]    min_ff;
   logic [R2_BITS-1:0]     r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= MATCH_RADIUS_RESET;
         fpd_ff    <= FRAMES_PER_DECAY_RESET;
         cap_ff    <= HIT_CAP_RESET;
         min_ff    <= MIN_HITS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MATCH_RADIUS:     radius_ff <= csr_wdata[RADIUS_BITS-1:0];
            CSR_FRAMES_PER_DECAY: fpd_ff    <= csr_wdata[FRAME_BITS-1:0];
            CSR_HIT_CAP:          cap_ff    <= csr_wdata[HIT_BITS-1:0];
            CSR_MIN_HITS:         min_ff    <= csr_wdata[HIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      r2_ff <= radius_ff * radius_ff;
   end

   // captured word
   req_word_type req_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
   end

   logic is_frame;
   assign is_frame = (req_ff.action == ACTION_FRAME_END);

   // table state
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [FRAME_BITS-1:0] frame_next;
   logic                  decay_due;

   assign frame_next = frame_ff + 1'b1;
   assign decay_due  = (frame_next >= fpd_ff);

   // read sweep
   logic [CNT_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] wr_ff, wr_in;
   logic             rd_more, issue;
   logic             v1_ff, v2_ff;
   logic [IDX_W-1:0] i1_ff, i2_ff;

   assign rd_more = (rd_ff < count_ff);
   assign issue   = cmd.run && rd_more;

   // entry memory
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   entry_type            ram_wdata;
   logic [$bits(entry_type)-1:0] ram_rdata;
   entry_type            rd_entry;

   dpt_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign rd_entry = entry_type'(ram_rdata);

   // stage 1: distance squares
   logic signed [COORD_BITS:0]    dx, dy;
   logic signed [2*COORD_BITS+1:0] dx_sq, dy_sq;

   assign dx    = $signed({1'b0, req_ff.point_x}) - $signed({1'b0, rd_entry.x});
   assign dy    = $signed({1'b0, req_ff.point_y}) - $signed({1'b0, rd_entry.y});
   assign dx_sq = dx * dx;
   assign dy_sq = dy * dy;

   logic [SQ_BITS-1:0]    sqx2_ff, sqy2_ff;
   logic [COORD_BITS-1:0] x2_ff, y2_ff;
   logic [HIT_BITS-1:0]   h2_ff;

   always_ff @(posedge clock) begin
      i2_ff   <= i1_ff;
      x2_ff   <= rd_entry.x;
      y2_ff   <= rd_entry.y;
      h2_ff   <= rd_entry.hits;
      sqx2_ff <= dx_sq[SQ_BITS-1:0];
      sqy2_ff <= dy_sq[SQ_BITS-1:0];
      i1_ff   <= rd_ff[IDX_W-1:0];
   end

   // stage 2: compare and track first match and best
   logic [D2_BITS-1:0]    d2;
   logic                  hit, first;
   logic [HIT_BITS-1:0]   cap, nh2, eff_h;
   logic [COORD_BITS-1:0] eff_x, eff_y;

   logic                  found_ff;
   logic [IDX_W-1:0]      m_ff;
   logic [HIT_BITS-1:0]   mh_ff;
   logic [HIT_BITS-1:0]   top_ff;
   logic [COORD_BITS-1:0] cand_x_ff, cand_y_ff;

   assign d2    = {1'b0, sqx2_ff} + {1'b0, sqy2_ff};
   assign hit   = (d2 <= D2_BITS'(r2_ff));
   assign cap   = (cap_ff == '0) ? FIRST_HITS : cap_ff;
   assign nh2   = (h2_ff < cap) ? HIT_BITS'(h2_ff + 1'b1) : cap;
   assign first = v2_ff && hit && !found_ff;
   assign eff_h = first ? nh2 : h2_ff;
   assign eff_x = first ? req_ff.point_x : x2_ff;
   assign eff_y = first ? req_ff.point_y : y2_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         found_ff  <= 1'b0;
         top_ff    <= '0;
         cand_x_ff <= '0;
         cand_y_ff <= '0;
      end else if (v2_ff) begin
         if (first) begin
            found_ff <= 1'b1;
            m_ff     <= i2_ff;
            mh_ff    <= nh2;
         end
         if (eff_h > top_ff) begin
            top_ff    <= eff_h;
            cand_x_ff <= eff_x;
            cand_y_ff <= eff_y;
         end
      end
   end

   // decay compaction writes straight from the read data
   logic [HIT_BITS-1:0] dec_h;
   logic                dec_we;

   assign dec_h  = (rd_entry.hits == '0) ? '0 : HIT_BITS'(rd_entry.hits - 1'b1);
   assign dec_we = v1_ff && is_frame && (dec_h != '0);

   // detection commit
   logic                  full, append;
   logic [HIT_BITS-1:0]   fin_top;
   logic [COORD_BITS-1:0] fin_x, fin_y;
   logic                  pick_new;

   assign full     = (count_ff == CNT_W'(ENTRIES));
   assign append   = !found_ff && !full;
   assign pick_new = append && (top_ff == '0);
   assign fin_top  = pick_new ? FIRST_HITS : top_ff;
   assign fin_x    = pick_new ? req_ff.point_x : cand_x_ff;
   assign fin_y    = pick_new ? req_ff.point_y : cand_y_ff;

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = wr_ff[IDX_W-1:0];
      ram_wdata = '{x: rd_entry.x, y: rd_entry.y, hits: dec_h};
      if (dec_we) begin
         ram_we = 1'b1;
      end else if (cmd.commit_det && found_ff) begin
         ram_we    = 1'b1;
         ram_waddr = m_ff;
         ram_wdata = '{x: req_ff.point_x, y: req_ff.point_y, hits: mh_ff};
      end else if (cmd.commit_det && append) begin
         ram_we    = 1'b1;
         ram_waddr = count_ff[IDX_W-1:0];
         ram_wdata = '{x: req_ff.point_x, y: req_ff.point_y, hits: FIRST_HITS};
      end
   end

   always_comb begin
      rd_in    = rd_ff;
      wr_in    = wr_ff;
      count_in = count_ff;
      frame_in = frame_ff;
      if (cmd.load) begin
         rd_in = '0;
         wr_in = '0;
      end else begin
         if (issue) begin
            rd_in = rd_ff + 1'b1;
         end
         if (dec_we) begin
            wr_in = wr_ff + 1'b1;
         end
      end
      if (cmd.commit_det && append) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.commit_frame) begin
         if (decay_due) begin
            count_in = wr_ff;
            frame_in = '0;
         end else begin
            frame_in = frame_next;
         end
      end
   end

   logic [COORD_BITS-1:0] best_x_ff, best_y_ff;
   logic                  dropped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         frame_ff   <= '0;
         rd_ff      <= '0;
         wr_ff      <= '0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         best_x_ff  <= '0;
         best_y_ff  <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         frame_ff <= frame_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         v1_ff    <= issue;
         v2_ff    <= v1_ff && !is_frame;
         if (cmd.commit_det) begin
            dropped_ff <= !found_ff && full;
            if (fin_top > min_ff) begin
               best_x_ff <= fin_x;
               best_y_ff <= fin_y;
            end else begin
               best_x_ff <= '0;
               best_y_ff <= '0;
            end
         end else if (cmd.commit_frame) begin
            dropped_ff <= 1'b0;
         end
      end
   end

   assign status.frame_end = is_frame;
   assign status.decay_due = decay_due;
   assign status.scan_done = !rd_more && !v1_ff && !v2_ff;

   assign rsp_word.best_x  = best_x_ff;
   assign rsp_word.best_y  = best_y_ff;
   assign rsp_word.dropped = dropped_ff;

endmodule

// ===== design/detection_persistence_tracker_core.sv =====
// Detection persistence tracker.
// Input: a word is taken on a clock edge with start high and busy low. Its
// action is either a detection point (point_x, point_y) or a frame end.
// Output: exactly one word per input, shown on rsp_word for one cycle with
// rsp_valid high; it carries the current best point and the dropped flag.
// The receiver cannot hold results off, and the block holds no more than
// the one result register.
// Flow: a detection is loaded, dispatched and then scanned, with one read of
// the entry memory per cycle over the stored entries feeding a two-stage
// distance pipe. A frame end with no decay due is committed straight from
// dispatch; one that triggers a decay sweeps the memory once and compacts it
// in place. One word is in flight at a time; busy drops in the strobe cycle,
// so the next start may be taken then. Registers are written through
// csr_wr_en/csr_index/csr_wdata; the user must write them only while idle,
// as the block itself does not enforce it.
// Reset (synchronous) empties the table, clears the frame counter and best
// point and loads the register defaults; no memory clearing pass is run.
module detection_persistence_tracker_core import dpt_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  req_word_type              req_word,
   output logic                      rsp_valid,
   output rsp_word_type              rsp_word,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   dpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   dpt_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== design/dpt_checker.sv =====
module dpt_checker import dpt_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input rsp_word_type rsp_word
);

   // an accepted word keeps the block busy until its result
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   // busy only ends with a result word
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("busy dropped without result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   // one result per word, never two in a row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back to back results");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_word))
      else $error("unknown bits in result word");

endmodule

bind detection_persistence_tracker_core dpt_checker u_dpt_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);
